// ===== design/stk_pkg.sv =====
// stk_pkg: shared types and codes for the bounded record stack.
// No dependencies; imported by the cell and the top level.
package stk_pkg;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;
  localparam logic [1:0] CMD_COUNT  = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic        [7:0]  kind;
    logic signed [15:0] girth;
    logic signed [15:0] age;
  } rec_t;

  typedef struct packed {
    logic load;   // take the incoming record
    logic shift;  // take the record of the cell below
  } cell_ctl_t;

endpackage

// ===== design/stk_if.sv =====
// stk_if: valid/ready channel interfaces for commands and results.
// Standalone; CNT_W sizes the count fields of the result channel.
interface stk_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  command;
  logic        [7:0]  item_kind;
  logic signed [15:0] item_girth;
  logic signed [15:0] item_age;

  modport source (output valid, command, item_kind, item_girth, item_age, input ready);
  modport sink   (input valid, command, item_kind, item_girth, item_age, output ready);
endinterface

interface stk_out_if #(
  parameter int CNT_W = 5
);
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic        [7:0]  out_kind;
  logic signed [15:0] out_girth;
  logic signed [15:0] out_age;
  logic [CNT_W-1:0]   match_count;
  logic [CNT_W-1:0]   fill_level;

  modport source (output valid, status, out_kind, out_girth, out_age, match_count,
                  fill_level, input ready);
  modport sink   (input valid, status, out_kind, out_girth, out_age, match_count,
                  fill_level, output ready);
endinterface

// ===== design/stk_cell.sv =====
// stk_cell: one stack entry; loads a new record, takes its lower neighbor's
// record, or holds. Compares its age for the count command. Uses stk_pkg.
module stk_cell (
  input  logic               clk,
  input  stk_pkg::cell_ctl_t ctl,
  input  stk_pkg::rec_t      item,
  input  stk_pkg::rec_t      below,
  input  logic signed [15:0] cmp_age,
  input  logic               occupied,
  output stk_pkg::rec_t      rec,
  output logic               match
);
  import stk_pkg::*;

  rec_t rec_r;
  rec_t rec_nxt;

  always_comb begin
    rec_nxt = rec_r;
    if (ctl.load) begin
      rec_nxt = item;
    end else if (ctl.shift) begin
      rec_nxt = below;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec   = rec_r;
  assign match = occupied && (rec_r.age == cmp_age);

endmodule

// ===== design/stk_popcnt.sv =====
// stk_popcnt: adder tree that counts the set bits of a match vector.
// No dependencies.
module stk_popcnt #(
  parameter int N = 16,
  parameter int W = 5
) (
  input  logic [N-1:0] bits,
  output logic [W-1:0] sum
);
  localparam int L = (N > 1) ? $clog2(N) : 1;
  localparam int P = 1 << L;

  logic [W-1:0] lvl [0:L][0:P-1];

  always_comb begin
    for (int l = 0; l <= L; l++) begin
      for (int j = 0; j < P; j++) begin
        lvl[l][j] = '0;
      end
    end
    for (int j = 0; j < N; j++) begin
      lvl[0][j] = {{(W-1){1'b0}}, bits[j]};
    end
    for (int l = 0; l < L; l++) begin
      for (int j = 0; j < (P >> (l + 1)); j++) begin
        lvl[l+1][j] = lvl[l][2*j] + lvl[l][2*j+1];
      end
    end
  end

  assign sum = lvl[L][0];

endmodule

// ===== design/stack_with_bottom_insert_and_count.sv =====
// stack_with_bottom_insert_and_count: bounded record stack built from a chain
// of stk_cell entries, with stk_popcnt for the age count. Uses stk_pkg, stk_if.
//
//   channel | dir | handshake            | payload
//   in_ch   | in  | valid/ready          | command, item_kind, item_girth, item_age
//   out_ch  | out | valid/ready          | status, out_kind, out_girth, out_age,
//           |     |                      | match_count, fill_level
//
// One transaction per cycle sustained unless stalled; the cell chain executes the
// command in the accept cycle; the result goes via s1 and the count tree to out_ch.
// Reset empties the stack (count to zero) and drops results in flight.
// A stalled output backs up through the result stage into in_ch.ready.
module stack_with_bottom_insert_and_count #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  stk_in_if.sink    in_ch,
  stk_out_if.source out_ch
);
  import stk_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  cell_ctl_t        ctl [DEPTH];
  rec_t             cell_rec [DEPTH];
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] occupied;
  rec_t             item;

  logic acc, full, empty, do_push, do_ins, do_pop;
  logic [IDX_W-1:0] pop_idx;
  logic [CNT_W-1:0] cnt_dec;

  logic             s1_v_r;
  logic [1:0]       s1_status_r, s1_status_nxt;
  rec_t             s1_rec_r, s1_rec_nxt;
  logic [DEPTH-1:0] s1_match_r;
  logic [CNT_W-1:0] s1_fill_r;
  logic             s1_adv;

  logic             out_v_r;
  logic [1:0]       out_status_r;
  rec_t             out_rec_r;
  logic [CNT_W-1:0] out_match_r, out_fill_r, pc_sum;

  assign acc     = in_ch.valid && in_ch.ready;
  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = acc && (in_ch.command == CMD_PUSH) && !full;
  assign do_ins  = acc && (in_ch.command == CMD_INSERT) && !full;
  assign do_pop  = acc && (in_ch.command == CMD_POP) && !empty;
  assign cnt_dec = cnt_r - CNT_W'(1);
  assign pop_idx = cnt_dec[IDX_W-1:0];

  assign item.kind  = in_ch.item_kind;
  assign item.girth = in_ch.item_girth;
  assign item.age   = in_ch.item_age;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occupied[i]  = (CNT_W'(i) < cnt_r);
      ctl[i].load  = (do_push && (CNT_W'(i) == cnt_r)) || (do_ins && (i == 0));
      ctl[i].shift = do_ins && (i != 0);
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      stk_cell u_cell (
        .clk      (clk),
        .ctl      (ctl[g]),
        .item     (item),
        .below    ((g == 0) ? item : cell_rec[(g == 0) ? 0 : g - 1]),
        .cmp_age  (in_ch.item_age),
        .occupied (occupied[g]),
        .rec      (cell_rec[g]),
        .match    (match[g])
      );
    end
  endgenerate

  always_comb begin
    cnt_nxt       = cnt_r;
    s1_status_nxt = ST_DONE;
    s1_rec_nxt    = '0;
    if (do_push || do_ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop) begin
      cnt_nxt    = cnt_dec;
      s1_rec_nxt = cell_rec[pop_idx];
    end
    if (((in_ch.command == CMD_PUSH) || (in_ch.command == CMD_INSERT)) && full) begin
      s1_status_nxt = ST_FULL;
    end else if ((in_ch.command == CMD_POP) && empty) begin
      s1_status_nxt = ST_EMPTY;
    end
  end

  assign s1_adv      = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_status_r <= s1_status_nxt;
      s1_rec_r    <= s1_rec_nxt;
      s1_match_r  <= (in_ch.command == CMD_COUNT) ? match : '0;
      s1_fill_r   <= cnt_nxt;
    end
    if (s1_adv) begin
      out_status_r <= s1_status_r;
      out_rec_r    <= s1_rec_r;
      out_match_r  <= pc_sum;
      out_fill_r   <= s1_fill_r;
    end
  end

  stk_popcnt #(
    .N (DEPTH),
    .W (CNT_W)
  ) u_popcnt (
    .bits (s1_match_r),
    .sum  (pc_sum)
  );

  assign out_ch.valid       = out_v_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.out_kind    = out_rec_r.kind;
  assign out_ch.out_girth   = out_rec_r.girth;
  assign out_ch.out_age     = out_rec_r.age;
  assign out_ch.match_count = out_match_r;
  assign out_ch.fill_level  = out_fill_r;

endmodule
